// File: hdl/i2a_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package i2a_pkg;

    localparam int BIN_BITS   = 64;
    localparam int DEC_DIGITS = 20;
    localparam int HEX_DIGITS = 16;
    localparam int BCD_BITS   = DEC_DIGITS * 4;
    localparam int NDIG_W     = 5;
    localparam int CNT_W      = 6;

    localparam logic [1:0] OP_UDEC = 2'd0;
    localparam logic [1:0] OP_SDEC = 2'd1;
    localparam logic [1:0] OP_HEX  = 2'd2;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;
    localparam logic [7:0] HEX_ALPHA  = 8'h57;

    typedef struct packed {
        logic [1:0]  op;
        logic [63:0] value;
        logic [5:0]  width;
        logic        zero_pad;
    } i2a_req_t;

    typedef struct packed {
        logic [7:0] char_out;
        logic       last;
    } i2a_rsp_t;

    typedef struct packed {
        logic start;
        logic shift;
    } i2a_cctl_t;

    typedef struct packed {
        logic              done;
        logic              neg;
        logic [NDIG_W-1:0] ndig;
        logic [3:0]        msd;
    } i2a_cstat_t;

    typedef enum logic [1:0] {
        C_IDLE,
        C_DABBLE,
        C_SCAN,
        C_DONE
    } i2a_cstate_t;

    typedef enum logic [2:0] {
        T_IDLE,
        T_CONV,
        T_PAD,
        T_SIGN,
        T_DIGIT
    } i2a_tstate_t;

endpackage

`default_nettype wire

// File: hdl/i2a_conv.sv
`timescale 1ns / 1ps
`default_nettype none

module i2a_conv (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire i2a_pkg::i2a_cctl_t ctl,
    input  wire logic [1:0]         op,
    input  wire logic [63:0]        value,
    output i2a_pkg::i2a_cstat_t     stat
);
    import i2a_pkg::*;

    i2a_cstate_t             state_reg, state_next;
    logic [BIN_BITS-1:0]     bin_reg, bin_next;
    logic [BCD_BITS-1:0]     bcd_reg, bcd_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [NDIG_W-1:0]       ndig_reg, ndig_next;
    logic                    neg_reg, neg_next;
    logic [BCD_BITS-1:0]     adj;
    logic                    is_hex;
    logic                    in_neg;
    logic                    lead_zero;

    always_comb begin
        case (op) inside
            OP_UDEC, OP_SDEC: is_hex = 1'b0;
            default:          is_hex = 1'b1;
        endcase
    end

    assign in_neg    = (op == OP_SDEC) && value[BIN_BITS-1];
    assign lead_zero = (ndig_reg > NDIG_W'(1)) && (bcd_reg[BCD_BITS-1 -: 4] == 4'd0);

    always_comb begin
        for (int i = 0; i < DEC_DIGITS; i++) begin
            if (bcd_reg[4*i +: 4] >= 4'd5) begin
                adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end else begin
                adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            C_IDLE, C_DONE: begin
                if (ctl.start) begin
                    state_next = is_hex ? C_SCAN : C_DABBLE;
                end
            end
            C_DABBLE: begin
                if (cnt_reg == CNT_W'(BIN_BITS - 1)) begin
                    state_next = C_SCAN;
                end
            end
            C_SCAN: begin
                if (!lead_zero) begin
                    state_next = C_DONE;
                end
            end
            default: state_next = C_IDLE;
        endcase
    end

    always_comb begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        ndig_next = ndig_reg;
        neg_next  = neg_reg;
        unique case (state_reg)
            C_IDLE, C_DONE: begin
                if (ctl.start) begin
                    neg_next = in_neg;
                    cnt_next = '0;
                    if (is_hex) begin
                        bcd_next  = {value, {(BCD_BITS - BIN_BITS){1'b0}}};
                        ndig_next = NDIG_W'(HEX_DIGITS);
                    end else begin
                        bcd_next  = '0;
                        bin_next  = in_neg ? (~value + 64'd1) : value;
                        ndig_next = NDIG_W'(DEC_DIGITS);
                    end
                end else if (ctl.shift) begin
                    bcd_next = {bcd_reg[BCD_BITS-5:0], 4'd0};
                end
            end
            C_DABBLE: begin
                bcd_next = {adj[BCD_BITS-2:0], bin_reg[BIN_BITS-1]};
                bin_next = {bin_reg[BIN_BITS-2:0], 1'b0};
                cnt_next = cnt_reg + CNT_W'(1);
            end
            C_SCAN: begin
                if (lead_zero) begin
                    bcd_next  = {bcd_reg[BCD_BITS-5:0], 4'd0};
                    ndig_next = ndig_reg - NDIG_W'(1);
                end
            end
            default: begin
                bcd_next = bcd_reg;
            end
        endcase
    end

    always_comb begin
        stat.done = (state_reg == C_DONE);
        stat.neg  = neg_reg;
        stat.ndig = ndig_reg;
        stat.msd  = bcd_reg[BCD_BITS-1 -: 4];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
        end else begin
            state_reg <= state_next;
        end
        bin_reg  <= bin_next;
        bcd_reg  <= bcd_next;
        cnt_reg  <= cnt_next;
        ndig_reg <= ndig_next;
        neg_reg  <= neg_next;
    end

endmodule

`default_nettype wire

// File: hdl/integer_to_ascii_padded_core.sv
// Conversion: decimal values run 64 shift-and-adjust steps, hex values are loaded directly;
// a scan then drops each suppressed leading zero before fill, sign and digits are sent.
// Throughput: one character per cycle while the output is taken; the next request is
// accepted the cycle after the final character enters the output register, so a new
// request is not taken before the previous one has sent its last character.
// Reset: synchronous, active low; clears the sequencers and the output valid.
`timescale 1ns / 1ps
`default_nettype none

module integer_to_ascii_padded_core #(
    parameter int MAX_WIDTH = 32
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire i2a_pkg::i2a_req_t s_req,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output i2a_pkg::i2a_rsp_t      m_rsp
);
    import i2a_pkg::*;

    localparam int LW = $clog2(MAX_WIDTH + 1);
    localparam int CW = (LW > 6) ? LW : 6;

    i2a_tstate_t       state_reg, state_next;
    logic [CW-1:0]     w_reg, w_next;
    logic [CW-1:0]     pad_reg, pad_next;
    logic [NDIG_W-1:0] dig_reg, dig_next;
    logic              zp_reg, zp_next;
    logic              m_valid_reg, m_valid_next;
    i2a_rsp_t          m_rsp_reg, m_rsp_next;

    i2a_cctl_t         cctl;
    i2a_cstat_t        cstat;

    logic              accept;
    logic              emit_ok;
    logic              emit;
    i2a_rsp_t          emit_rsp;
    logic [CW-1:0]     w_sat;
    logic [CW-1:0]     text_len;
    logic [CW-1:0]     pad_calc;
    logic [7:0]        fill;

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        if (d < 4'd10) begin
            return CHAR_ZERO + 8'(d);
        end
        return HEX_ALPHA + 8'(d);
    endfunction

    i2a_conv u_conv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (cctl),
        .op      (s_req.op),
        .value   (s_req.value),
        .stat    (cstat)
    );

    assign accept   = s_valid && s_ready;
    assign emit_ok  = !m_valid_reg || m_ready;
    assign w_sat    = (CW'(s_req.width) > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH)
                                                           : CW'(s_req.width);
    assign text_len = CW'(cstat.ndig) + CW'(cstat.neg);
    assign pad_calc = (w_reg > text_len) ? (w_reg - text_len) : '0;
    assign fill     = zp_reg ? CHAR_ZERO : CHAR_SPACE;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            T_IDLE: begin
                if (s_valid) begin
                    state_next = T_CONV;
                end
            end
            T_CONV: begin
                if (cstat.done) begin
                    if (pad_calc != '0) begin
                        state_next = T_PAD;
                    end else if (cstat.neg) begin
                        state_next = T_SIGN;
                    end else begin
                        state_next = T_DIGIT;
                    end
                end
            end
            T_PAD: begin
                if (emit_ok && pad_reg == CW'(1)) begin
                    state_next = cstat.neg ? T_SIGN : T_DIGIT;
                end
            end
            T_SIGN: begin
                if (emit_ok) begin
                    state_next = T_DIGIT;
                end
            end
            T_DIGIT: begin
                if (emit_ok && dig_reg == NDIG_W'(1)) begin
                    state_next = T_IDLE;
                end
            end
            default: state_next = T_IDLE;
        endcase
    end

    always_comb begin
        s_ready           = 1'b0;
        emit              = 1'b0;
        emit_rsp.char_out = fill;
        emit_rsp.last     = 1'b0;
        cctl.start        = 1'b0;
        cctl.shift        = 1'b0;
        unique case (state_reg)
            T_IDLE: begin
                s_ready    = 1'b1;
                cctl.start = s_valid;
            end
            T_CONV: begin
                emit = 1'b0;
            end
            T_PAD: begin
                emit = emit_ok;
            end
            T_SIGN: begin
                emit              = emit_ok;
                emit_rsp.char_out = CHAR_MINUS;
            end
            T_DIGIT: begin
                emit              = emit_ok;
                emit_rsp.char_out = digit_char(cstat.msd);
                emit_rsp.last     = (dig_reg == NDIG_W'(1));
                cctl.shift        = emit_ok;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    always_comb begin
        w_next       = w_reg;
        zp_next      = zp_reg;
        pad_next     = pad_reg;
        dig_next     = dig_reg;
        m_valid_next = m_valid_reg;
        m_rsp_next   = m_rsp_reg;
        if (accept) begin
            w_next  = w_sat;
            zp_next = s_req.zero_pad;
        end
        if (state_reg == T_CONV && cstat.done) begin
            pad_next = pad_calc;
            dig_next = cstat.ndig;
        end
        if (state_reg == T_PAD && emit) begin
            pad_next = pad_reg - CW'(1);
        end
        if (state_reg == T_DIGIT && emit) begin
            dig_next = dig_reg - NDIG_W'(1);
        end
        if (emit) begin
            m_valid_next = 1'b1;
            m_rsp_next   = emit_rsp;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= T_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        w_reg     <= w_next;
        zp_reg    <= zp_next;
        pad_reg   <= pad_next;
        dig_reg   <= dig_next;
        m_rsp_reg <= m_rsp_next;
    end

    assign m_valid = m_valid_reg;
    assign m_rsp   = m_rsp_reg;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("request accepted while previous conversion pending");

    a_last_ends_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && emit_rsp.last) |=> (state_reg == T_IDLE))
        else $error("sequencer did not return to idle after final character");

    a_digits_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == T_DIGIT) |-> (cstat.done && dig_reg != '0))
        else $error("digit emission without finished conversion");

    a_pad_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == T_PAD) |-> (pad_reg != '0))
        else $error("fill emission with empty fill count");
`endif

endmodule

`default_nettype wire

// File: sim/tb_integer_to_ascii_padded_core.sv
`timescale 1ns / 1ps

module tb_integer_to_ascii_padded_core;
    import i2a_pkg::*;

    localparam int MAX_W        = 32;
    localparam int RANDOM_ITEMS = 390;
    localparam int QUIET_ITEMS  = 60;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 100;
    localparam int CYCLE_LIMIT  = 800000;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        i2a_req_t req;
        string    txt;
    } dir_row_t;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    i2a_req_t s_req;
    logic     m_valid;
    logic     m_ready;
    i2a_rsp_t m_rsp;

    i2a_rsp_t pending_chars[$];
    dir_row_t dir_rows[$];
    int       mismatch_count = 0;
    int       cycle_count = 0;
    bit       idle_on = 1'b1;
    bit       rx_hold_req = 1'b0;

    integer_to_ascii_padded_core #(
        .MAX_WIDTH(MAX_W)
    ) dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_req  (s_req),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_rsp  (m_rsp)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic string format_number(i2a_req_t r);
        string       digits;
        string       txt;
        logic [63:0] mag;
        logic [63:0] base;
        logic [63:0] d;
        logic [7:0]  fill;
        bit          neg;
        int          w;
        digits = "";
        txt = "";
        mag = r.value;
        base = 64'd10;
        neg = 1'b0;
        // op 3 falls through to hex
        if (r.op[1]) begin
            base = 64'd16;
        end else if (r.op == OP_SDEC && r.value[63]) begin
            neg = 1'b1;
            mag = ~r.value + 64'd1;
        end
        do begin
            d = mag % base;
            mag = mag / base;
            digits = $sformatf("%c%s", (d < 10) ? CHAR_ZERO + d[7:0] : HEX_ALPHA + d[7:0],
                               digits);
        end while (mag != 0);
        if (neg) begin
            digits = $sformatf("%c%s", CHAR_MINUS, digits);
        end
        w = (int'(r.width) > MAX_W) ? MAX_W : int'(r.width);
        fill = r.zero_pad ? CHAR_ZERO : CHAR_SPACE;
        for (int k = digits.len(); k < w; k++) begin
            txt = $sformatf("%s%c", txt, fill);
        end
        return {txt, digits};
    endfunction

    function automatic void queue_text(string txt);
        i2a_rsp_t c;
        for (int k = 0; k < txt.len(); k++) begin
            c.char_out = txt[k];
            c.last = (k == txt.len() - 1);
            pending_chars.push_back(c);
        end
    endfunction

    function automatic void add_row(logic [1:0] op, logic [63:0] value, int w, bit zp,
                                    string txt);
        dir_row_t row;
        row.req.op = op;
        row.req.value = value;
        row.req.width = w[5:0];
        row.req.zero_pad = zp;
        row.txt = txt;
        dir_rows.push_back(row);
    endfunction

    // offer one request; empty txt means predict it
    task automatic offer(i2a_req_t r, string txt);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_req <= r;
        do @(posedge aclk); while (!s_ready);
        queue_text(txt == "" ? format_number(r) : txt);
        @(negedge aclk);
    endtask

    always @(posedge aclk) begin
        i2a_rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_chars.size() == 0) begin
                report_mismatch($sformatf("unexpected char 0x%02h last %0b",
                                          m_rsp.char_out, m_rsp.last));
            end else begin
                want = pending_chars.pop_front();
                if (m_rsp.char_out !== want.char_out) begin
                    report_mismatch($sformatf("char_out 0x%02h, want 0x%02h",
                                              m_rsp.char_out, want.char_out));
                end
                if (m_rsp.last !== want.last) begin
                    report_mismatch($sformatf("last %0b, want %0b on char 0x%02h",
                                              m_rsp.last, want.last, want.char_out));
                end
            end
        end
    end

    initial begin
        m_ready = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(negedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    initial begin
        i2a_req_t    r;
        logic [63:0] p;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_req = '0;

        add_row(OP_UDEC, 64'd0, 0, 1'b0, "0");
        add_row(OP_UDEC, '1, 0, 1'b0, "18446744073709551615");
        add_row(OP_SDEC, 64'd0, 0, 1'b1, "0");
        add_row(OP_SDEC, '1, 0, 1'b0, "-1");
        add_row(OP_SDEC, 64'h8000_0000_0000_0000, 0, 1'b0, "-9223372036854775808");
        add_row(OP_SDEC, 64'h7fff_ffff_ffff_ffff, 0, 1'b0, "9223372036854775807");
        add_row(OP_HEX, 64'd0, 0, 1'b0, "0");
        add_row(OP_HEX, '1, 0, 1'b0, "ffffffffffffffff");
        add_row(OP_HEX, 64'h0123_4567_89ab_cdef, 0, 1'b0, "123456789abcdef");
        add_row(OP_UNUSED, 64'hfedc_ba98_7654_3210, 0, 1'b0, "fedcba9876543210");
        add_row(OP_UDEC, 64'd42, 5, 1'b1, "00042");
        add_row(OP_UDEC, 64'd42, 5, 1'b0, "   42");
        add_row(OP_SDEC, -64'sd5, 4, 1'b1, "00-5");
        add_row(OP_SDEC, -64'sd5, 4, 1'b0, "  -5");
        add_row(OP_UDEC, 64'd123456, 3, 1'b1, "123456");
        add_row(OP_UDEC, 64'd7, 1, 1'b1, "7");
        add_row(OP_UDEC, '1, 20, 1'b1, "18446744073709551615");
        add_row(OP_UDEC, 64'd10, 2, 1'b0, "10");
        add_row(OP_SDEC, 64'd100, 0, 1'b0, "100");
        add_row(OP_UDEC, 64'd9, 32, 1'b1, "");
        add_row(OP_HEX, 64'd1, 63, 1'b0, "");
        add_row(OP_SDEC, 64'h8000_0000_0000_0000, 33, 1'b1, "");
        add_row(OP_UNUSED, 64'ha, 40, 1'b1, "");
        add_row(OP_SDEC, '1, 31, 1'b0, "");

        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (dir_rows[i]) begin
            offer(dir_rows[i].req, dir_rows[i].txt);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 100) begin
                rx_hold_req = 1'b1;
            end
            if (n == 200) begin
                s_valid <= 1'b0;
                wait (pending_chars.size() == 0);
                @(negedge aclk);
            end
            if (n == RANDOM_ITEMS - QUIET_ITEMS) begin
                idle_on = 1'b0;
            end
            r.op = ($urandom_range(0, 9) == 0) ? OP_UNUSED : 2'($urandom_range(0, 2));
            case ($urandom_range(0, 5))
                0: r.value = {$urandom, $urandom};
                1: r.value = 64'($urandom_range(0, 20));
                2: r.value = {$urandom, $urandom} >> $urandom_range(0, 63);
                3: r.value = ~({$urandom, $urandom} >> $urandom_range(0, 63));
                4: begin
                    case ($urandom_range(0, 3))
                        0: r.value = 64'h8000_0000_0000_0000;
                        1: r.value = 64'h7fff_ffff_ffff_ffff;
                        2: r.value = '1;
                        default: r.value = 64'd1;
                    endcase
                end
                default: begin
                    p = 64'd1;
                    repeat ($urandom_range(0, 19)) p = p * 64'd10;
                    r.value = p + 64'($urandom_range(0, 2)) - 64'd1;
                end
            endcase
            r.width = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                                  : 6'($urandom_range(0, 24));
            r.zero_pad = 1'($urandom_range(0, 1));
            offer(r, "");
        end
        s_valid <= 1'b0;

        wait (pending_chars.size() == 0);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
